[rtl/core/assert_macros.svh]
// Assertion macros for the RTL of the NTC converter.
// No dependencies; the bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property checked at every rising clock edge, held off while reset is low.
`define NTC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Property checked at every rising clock edge, also during reset.
`define NTC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define NTC_ASSERT(lbl, clk, rst_n, prop, msg)
`define NTC_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

[rtl/core/ntcat_pkg.sv]
// Constants, the NTC resistance table and helper functions of the NTC converter.
// No dependencies; used by ntc_adc_to_temperature_top.
package ntcat_pkg;

  localparam int ADC_BITS      = 12;
  localparam int TABLE_ENTRIES = 37;
  localparam int TABLE_STORED  = 37;
  localparam int ENTRIES       = (TABLE_ENTRIES < TABLE_STORED) ? TABLE_ENTRIES : TABLE_STORED;
  localparam int IDX_W         = $clog2(ENTRIES + 1);

  localparam int SR_W   = 20;
  localparam int RES_W  = 26;
  localparam int TEMP_W = 16;
  localparam int R10_W  = RES_W + 4;
  localparam int TAB_W  = 24;
  localparam int PROD_W = SR_W + ADC_BITS;
  localparam int Q2_BITS = 11;
  localparam int NUM_W  = TAB_W + Q2_BITS;
  localparam int QW     = (PROD_W > Q2_BITS) ? PROD_W : Q2_BITS;
  localparam int CNT_W  = $clog2(QW + 1);

  localparam logic [ADC_BITS-1:0] FULL_SCALE = {ADC_BITS{1'b1}};
  localparam logic [RES_W-1:0]    RES_MAX    = {RES_W{1'b1}};
  localparam logic [SR_W-1:0]     SR_RESET   = SR_W'(10000);

  localparam int COLD_C = -55;
  localparam int STEP_C = 5;
  localparam logic signed [TEMP_W-1:0] COLD_Q8 = TEMP_W'(COLD_C * 256);
  localparam logic signed [TEMP_W-1:0] HOT_Q8  =
    TEMP_W'((COLD_C + STEP_C * (ENTRIES - 1)) * 256);

  // NTC resistance in tenths of an ohm, one entry per 5 C from -55 C.
  function automatic logic [TAB_W-1:0] ntc_tenths(input logic [IDX_W-1:0] idx);
    logic [TAB_W-1:0] v;
    case (idx)
      IDX_W'(0):  v = TAB_W'(12146000);
      IDX_W'(1):  v = TAB_W'(8443900);
      IDX_W'(2):  v = TAB_W'(5924300);
      IDX_W'(3):  v = TAB_W'(4193800);
      IDX_W'(4):  v = TAB_W'(2994800);
      IDX_W'(5):  v = TAB_W'(2156700);
      IDX_W'(6):  v = TAB_W'(1564100);
      IDX_W'(7):  v = TAB_W'(1146600);
      IDX_W'(8):  v = TAB_W'(845100);
      IDX_W'(9):  v = TAB_W'(629270);
      IDX_W'(10): v = TAB_W'(470770);
      IDX_W'(11): v = TAB_W'(355630);
      IDX_W'(12): v = TAB_W'(271190);
      IDX_W'(13): v = TAB_W'(208600);
      IDX_W'(14): v = TAB_W'(162040);
      IDX_W'(15): v = TAB_W'(126830);
      IDX_W'(16): v = TAB_W'(100000);
      IDX_W'(17): v = TAB_W'(79420);
      IDX_W'(18): v = TAB_W'(63270);
      IDX_W'(19): v = TAB_W'(50740);
      IDX_W'(20): v = TAB_W'(41030);
      IDX_W'(21): v = TAB_W'(33360);
      IDX_W'(22): v = TAB_W'(27240);
      IDX_W'(23): v = TAB_W'(22370);
      IDX_W'(24): v = TAB_W'(18460);
      IDX_W'(25): v = TAB_W'(15300);
      IDX_W'(26): v = TAB_W'(12750);
      IDX_W'(27): v = TAB_W'(10680);
      IDX_W'(28): v = TAB_W'(8993);
      IDX_W'(29): v = TAB_W'(7607);
      IDX_W'(30): v = TAB_W'(6452);
      IDX_W'(31): v = TAB_W'(5494);
      IDX_W'(32): v = TAB_W'(4700);
      IDX_W'(33): v = TAB_W'(4036);
      IDX_W'(34): v = TAB_W'(3474);
      IDX_W'(35): v = TAB_W'(3001);
      IDX_W'(36): v = TAB_W'(2601);
      default:    v = '0;
    endcase
    return v;
  endfunction

  // Temperature of table entry idx in Q8.8 degrees C.
  function automatic logic signed [TEMP_W-1:0] entry_q8(input logic [IDX_W-1:0] idx);
    return TEMP_W'((COLD_C + STEP_C * int'(idx)) * 256);
  endfunction

endpackage

[rtl/core/ntc_adc_to_temperature_top.sv]
// Top level of the NTC thermistor converter: ADC code in, Q8.8 temperature out.
// Depends on ntcat_pkg and on assert_macros.svh for its assertions.
// Contains the sequencer and the shared restoring divider.

// This block turns one 12-bit ADC sample of a series-resistor / NTC divider into
// the thermistor resistance, series_resistor_ohms * code / (4095 - code) in whole
// ohms saturating at 2^26 - 1, and then into a Q8.8 temperature by a linear
// interpolation between the two neighboring entries of a 37-entry table that
// runs from -55 C to 125 C in 5 C steps. A code of 4095 or a resistance outside
// the table clamps the temperature to -55 C or 125 C and raises out_of_range.
// The block works on one beat at a time and in_tready is low while it is busy.
// A beat with an ordinary code goes through the resistance division, saturation,
// scaling, the table search, the fraction division and the interpolation before
// its result beat is shown. The open-sensor code 4095 skips the division, a
// resistance above the first entry ends the search there, and one at or below the
// last entry walks the whole table to its end. The time taken is set by the
// shared one-bit-per-cycle divider (32 steps for the resistance, 11 steps for the
// interpolation fraction) and by the table search, which tests one entry per
// cycle. The result sits in an output register, so the next input beat can be
// taken while a result still waits for out_tready; a finished result waits for
// as long as the one before it is still held there. The series resistor register
// is written with cfg_wr_en and should only change while the block is idle.

`include "assert_macros.svh"

module ntc_adc_to_temperature_top (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration: series resistor in ohms.
  input  logic        cfg_wr_en,
  input  logic [19:0] cfg_wr_data,
  // Input stream. tdata: [11:0] adc_code, [15:12] zero.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,
  // tuser: [0] channel_tag.
  input  logic [0:0]  in_tuser,
  // Result stream. tdata: [15:0] temperature_q8, [41:16] resistance_ohms,
  // [42] out_of_range, [47:43] zero.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,
  // tuser: [0] channel_tag_out.
  output logic [0:0]  out_tuser
);

  typedef enum logic [9:0] {
    S_IDLE   = 10'b00_0000_0001,
    S_DIV1   = 10'b00_0000_0010,
    S_SAT    = 10'b00_0000_0100,
    S_SCALE  = 10'b00_0000_1000,
    S_SEARCH = 10'b00_0001_0000,
    S_PREP   = 10'b00_0010_0000,
    S_NUM    = 10'b00_0100_0000,
    S_DIV2   = 10'b00_1000_0000,
    S_INTERP = 10'b01_0000_0000,
    S_DONE   = 10'b10_0000_0000
  } state_t;

  // Control registers.
  state_t                       state_r, state_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [ntcat_pkg::SR_W-1:0]   sr_r, sr_nxt;

  // Datapath registers.
  logic [ntcat_pkg::QW-1:0]     quo_r, quo_nxt;
  logic [ntcat_pkg::TAB_W-1:0]  rem_r, rem_nxt;
  logic [ntcat_pkg::TAB_W-1:0]  den_r, den_nxt;
  logic [ntcat_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [ntcat_pkg::RES_W-1:0]  res_r, res_nxt;
  logic [ntcat_pkg::R10_W-1:0]  r10_r, r10_nxt;
  logic [ntcat_pkg::IDX_W-1:0]  idx_r, idx_nxt;
  logic signed [ntcat_pkg::TEMP_W-1:0] temp_r, temp_nxt;
  logic                         oor_r, oor_nxt;
  logic                         tag_r, tag_nxt;

  logic signed [ntcat_pkg::TEMP_W-1:0] out_temp_r, out_temp_nxt;
  logic [ntcat_pkg::RES_W-1:0]  out_res_r, out_res_nxt;
  logic                         out_oor_r, out_oor_nxt;
  logic                         out_tag_r, out_tag_nxt;

  // Shared restoring divider step: one quotient bit per cycle.
  logic [ntcat_pkg::TAB_W+1:0]  div_diff;
  logic                         div_bit;
  logic [ntcat_pkg::TAB_W-1:0]  div_rem;
  logic [ntcat_pkg::TAB_W:0]    div_shift;

  // Table reads and interpolation terms.
  logic [ntcat_pkg::TAB_W-1:0]  tab_cur;
  logic [ntcat_pkg::TAB_W-1:0]  tab_prev;
  logic [ntcat_pkg::NUM_W-1:0]  num;
  logic [ntcat_pkg::ADC_BITS-1:0] in_code;
  logic                         in_fire;
  logic                         out_free;

  assign in_code   = in_tdata[ntcat_pkg::ADC_BITS-1:0];
  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  assign div_shift = {rem_r, quo_r[ntcat_pkg::QW-1]};
  assign div_diff  = {1'b0, div_shift} - {2'b00, den_r};
  assign div_bit   = !div_diff[ntcat_pkg::TAB_W+1];
  // Either way the new partial remainder is below the divisor, so it fits.
  assign div_rem   = div_bit ? div_diff[ntcat_pkg::TAB_W-1:0]
                             : div_shift[ntcat_pkg::TAB_W-1:0];

  assign tab_cur  = ntcat_pkg::ntc_tenths(idx_r);
  assign tab_prev = ntcat_pkg::ntc_tenths(idx_r - ntcat_pkg::IDX_W'(1));

  // rem_r holds the offset d and den_r the table step here: 1280*d + den/2.
  assign num = (ntcat_pkg::NUM_W'(rem_r) << 10) + (ntcat_pkg::NUM_W'(rem_r) << 8)
             + ntcat_pkg::NUM_W'(den_r >> 1);

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    sr_nxt        = sr_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    den_nxt       = den_r;
    cnt_nxt       = cnt_r;
    res_nxt       = res_r;
    r10_nxt       = r10_r;
    idx_nxt       = idx_r;
    temp_nxt      = temp_r;
    oor_nxt       = oor_r;
    tag_nxt       = tag_r;
    out_temp_nxt  = out_temp_r;
    out_res_nxt   = out_res_r;
    out_oor_nxt   = out_oor_r;
    out_tag_nxt   = out_tag_r;

    if (cfg_wr_en) begin
      sr_nxt = cfg_wr_data;
    end

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          tag_nxt = in_tuser[0];
          if (in_code >= ntcat_pkg::FULL_SCALE) begin
            // An open divider reads as infinite resistance.
            res_nxt   = ntcat_pkg::RES_MAX;
            state_nxt = S_SCALE;
          end else begin
            quo_nxt   = ntcat_pkg::QW'(sr_r * in_code);
            rem_nxt   = '0;
            den_nxt   = ntcat_pkg::TAB_W'(ntcat_pkg::FULL_SCALE - in_code);
            cnt_nxt   = ntcat_pkg::CNT_W'(ntcat_pkg::PROD_W);
            state_nxt = S_DIV1;
          end
        end
      end
      S_DIV1, S_DIV2: begin
        rem_nxt = div_rem;
        quo_nxt = {quo_r[ntcat_pkg::QW-2:0], div_bit};
        cnt_nxt = cnt_r - ntcat_pkg::CNT_W'(1);
        if (cnt_r == ntcat_pkg::CNT_W'(1)) begin
          state_nxt = (state_r == S_DIV1) ? S_SAT : S_INTERP;
        end
      end
      S_SAT: begin
        res_nxt   = (|quo_r[ntcat_pkg::QW-1:ntcat_pkg::RES_W]) ? ntcat_pkg::RES_MAX
                                                               : quo_r[ntcat_pkg::RES_W-1:0];
        state_nxt = S_SCALE;
      end
      S_SCALE: begin
        r10_nxt   = (ntcat_pkg::R10_W'(res_r) << 3) + (ntcat_pkg::R10_W'(res_r) << 1);
        idx_nxt   = '0;
        state_nxt = S_SEARCH;
      end
      S_SEARCH: begin
        priority if (idx_r == ntcat_pkg::IDX_W'(ntcat_pkg::ENTRIES)) begin
          temp_nxt  = ntcat_pkg::HOT_Q8;
          oor_nxt   = 1'b1;
          state_nxt = S_DONE;
        end else if (r10_r > ntcat_pkg::R10_W'(tab_cur)) begin
          if (idx_r == '0) begin
            temp_nxt  = ntcat_pkg::COLD_Q8;
            oor_nxt   = 1'b1;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_PREP;
          end
        end else begin
          idx_nxt = idx_r + ntcat_pkg::IDX_W'(1);
        end
      end
      S_PREP: begin
        // The offset never exceeds the table step, so it fits the table width.
        rem_nxt   = ntcat_pkg::TAB_W'(r10_r - ntcat_pkg::R10_W'(tab_cur));
        den_nxt   = tab_prev - tab_cur;
        state_nxt = S_NUM;
      end
      S_NUM: begin
        // The fraction is at most 1280, so only its low bits need iterating.
        rem_nxt   = num[ntcat_pkg::NUM_W-1:ntcat_pkg::Q2_BITS];
        quo_nxt   = {num[ntcat_pkg::Q2_BITS-1:0], {(ntcat_pkg::QW-ntcat_pkg::Q2_BITS){1'b0}}};
        cnt_nxt   = ntcat_pkg::CNT_W'(ntcat_pkg::Q2_BITS);
        state_nxt = S_DIV2;
      end
      S_INTERP: begin
        temp_nxt  = ntcat_pkg::entry_q8(idx_r)
                  - ntcat_pkg::TEMP_W'(quo_r[ntcat_pkg::Q2_BITS-1:0]);
        oor_nxt   = 1'b0;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          out_temp_nxt  = temp_r;
          out_res_nxt   = res_r;
          out_oor_nxt   = oor_r;
          out_tag_nxt   = tag_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      sr_r        <= ntcat_pkg::SR_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      sr_r        <= sr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r      <= quo_nxt;
    rem_r      <= rem_nxt;
    den_r      <= den_nxt;
    cnt_r      <= cnt_nxt;
    res_r      <= res_nxt;
    r10_r      <= r10_nxt;
    idx_r      <= idx_nxt;
    temp_r     <= temp_nxt;
    oor_r      <= oor_nxt;
    tag_r      <= tag_nxt;
    out_temp_r <= out_temp_nxt;
    out_res_r  <= out_res_nxt;
    out_oor_r  <= out_oor_nxt;
    out_tag_r  <= out_tag_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0_0000, out_oor_r, out_res_r, out_temp_r};
  assign out_tuser  = out_tag_r;

  // An accepted beat starts either the resistance division or the open-divider path.
  `NTC_ASSERT(a_accept_start, clk, rst_n,
    in_fire |=> (state_r == S_DIV1 || state_r == S_SCALE), "accepted beat did not start work")
  // The divider always has steps left while it is running.
  `NTC_ASSERT(a_div_count, clk, rst_n,
    (state_r == S_DIV1 || state_r == S_DIV2) |-> (cnt_r != '0), "divider ran out of steps")
  // The table search never goes past the end marker.
  `NTC_ASSERT(a_search_bound, clk, rst_n,
    (state_r == S_SEARCH) |-> (idx_r <= ntcat_pkg::IDX_W'(ntcat_pkg::ENTRIES)),
    "table search index out of bounds")
  // A clamped result carries one of the two clamp temperatures.
  `NTC_ASSERT(a_clamp_value, clk, rst_n,
    (out_valid_r && out_oor_r) |->
      (out_temp_r == ntcat_pkg::COLD_Q8 || out_temp_r == ntcat_pkg::HOT_Q8),
    "clamped result with unexpected temperature")
  // A saturated resistance is always beyond the cold end of the table.
  `NTC_ASSERT(a_sat_oor, clk, rst_n,
    (out_valid_r && out_res_r == ntcat_pkg::RES_MAX) |-> out_oor_r,
    "saturated resistance without out_of_range")

endmodule
